// ===== hw/rtl/agau_pkg.sv =====
`timescale 1ns / 1ps
package agau_pkg;

  localparam int INDEX_W    = 17;
  localparam int OUT_ADDR_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int AXIS_W     = 16;
  localparam int TILE_LEN_W = 7;
  localparam int COUNT_W    = 16;
  localparam int SRC_LEN_W  = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS_SIZE     = 3'd0,
    CFG_TILE_LENGTH   = 3'd1,
    CFG_INDEX_COUNT   = 3'd2,
    CFG_OUTER_COUNT   = 3'd3,
    CFG_SOURCE_LENGTH = 3'd4
  } cfg_reg_e;

  // per-tile control that travels with the descriptor through the queue
  typedef struct packed {
    logic [TILE_LEN_W-1:0] len;
    logic                  copy;
    logic                  job_end;
  } tile_ctrl_t;

endpackage

// ===== hw/rtl/agau_if.sv =====
`timescale 1ns / 1ps
interface agau_index_if;
  import agau_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [INDEX_W-1:0] index_value;
  modport source(output valid, index_value, input ready);
  modport sink(input valid, index_value, output ready);
endinterface

interface agau_result_if;
  import agau_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OUT_ADDR_W-1:0] source_address;
  logic [OUT_ADDR_W-1:0] dest_address;
  logic                  copy_valid;
  logic                  tile_end;
  logic                  job_end;
  modport source(output valid, source_address, dest_address, copy_valid, tile_end, job_end,
                 input ready);
  modport sink(input valid, source_address, dest_address, copy_valid, tile_end, job_end,
               output ready);
endinterface

// ===== hw/rtl/axis_gather_address_generator_unit.sv =====
`timescale 1ns / 1ps
// Gather address sequencer. Each index transaction on index_ch (a signed index,
// wrapped once by axis_size when negative) expands into one result transaction
// per element of its tile on result_ch, carrying source and destination element
// offsets, tile_end on the last element and job_end on the last element of the
// job. A tile whose source start is negative or not below source_length gives a
// single result with copy_valid low and source_address zero. The front end
// takes each index through three steps (registered 16x16 outer-stride multiply,
// then the multiply by tile length, then range check and queue push) and accepts
// a new index only once the last one is pushed. The back end issues one result
// per cycle while a tile is queued and result_ch is not stalled: one per element
// of an ordinary tile, one for a skipped tile. A two-entry tile queue lets the
// front run ahead while results stall. Configuration must be written through
// cfg_we_i/cfg_idx_i/cfg_data_i only while idle; the block does not enforce this.
module axis_gather_address_generator_unit #(
  parameter int ADDR_WIDTH = 24,
  parameter int MAX_TILE   = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  agau_index_if.sink                      index_ch,
  agau_result_if.source                   result_ch,
  input  logic                            cfg_we_i,
  input  logic [agau_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [agau_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import agau_pkg::*;

  localparam int QueueDepth = 2;
  localparam int DescW      = 2 * ADDR_WIDTH + $bits(tile_ctrl_t);

  logic                  push_valid, queue_full, queue_empty, pop;
  logic [ADDR_WIDTH-1:0] push_start, push_dest, head_start, head_dest;
  tile_ctrl_t            push_ctrl, head_ctrl;
  logic [DescW-1:0]      push_desc, head_desc;

  // front end: config, position tracking, start computation, range check
  agau_front #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .MAX_TILE   (MAX_TILE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .index_ch     (index_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (!queue_full),
    .push_start_o (push_start),
    .push_dest_o  (push_dest),
    .push_ctrl_o  (push_ctrl)
  );

  assign push_desc = {push_start, push_dest, push_ctrl};

  // tile descriptor queue
  agau_fifo #(
    .WIDTH (DescW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_data_i (push_desc),
    .full_o      (queue_full),
    .pop_i       (pop),
    .head_data_o (head_desc),
    .empty_o     (queue_empty)
  );

  assign {head_start, head_dest, head_ctrl} = head_desc;

  // back end: element expansion and output register
  agau_back #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!queue_empty),
    .head_start_i (head_start),
    .head_dest_i  (head_dest),
    .head_ctrl_i  (head_ctrl),
    .pop_o        (pop),
    .result_ch    (result_ch)
  );

endmodule

// ===== hw/rtl/agau_front.sv =====
`timescale 1ns / 1ps
module agau_front #(
  parameter int ADDR_WIDTH = 24,
  parameter int MAX_TILE   = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  agau_index_if.sink                   index_ch,
  input  logic                         cfg_we_i,
  input  logic [agau_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [agau_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output logic [ADDR_WIDTH-1:0]        push_start_o,
  output logic [ADDR_WIDTH-1:0]        push_dest_o,
  output agau_pkg::tile_ctrl_t         push_ctrl_o
);
  import agau_pkg::*;

  typedef enum logic [2:0] {
    FS_IDLE  = 3'b001,
    FS_SCALE = 3'b010,
    FS_PUSH  = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;

  // configuration
  logic [AXIS_W-1:0]     axis_q;
  logic [TILE_LEN_W-1:0] tile_len_q;
  logic [COUNT_W-1:0]    index_cnt_q;
  logic [COUNT_W-1:0]    outer_cnt_q;
  logic [SRC_LEN_W-1:0]  src_len_q;

  // sequencing state
  logic [COUNT_W-1:0]    index_pos_q, index_pos_d;
  logic [COUNT_W-1:0]    outer_pos_q, outer_pos_d;
  logic [ADDR_WIDTH-1:0] dest_base_q, dest_base_d;

  // per-item working registers
  logic [31:0]            prod_q;
  logic signed [17:0]     idx_w_q;
  logic [TILE_LEN_W-1:0]  len_q;
  logic [ADDR_WIDTH-1:0]  dest_q;
  logic                   jend_q;
  logic signed [41:0]     start_q;

  logic                   accept;
  logic [TILE_LEN_W-1:0]  len_eff;
  logic [COUNT_W-1:0]     ic_eff, oc_eff;
  logic                   last_index, last_outer, jend;
  logic signed [17:0]     idx_ext, idx_w;
  logic signed [33:0]     sum;
  logic signed [41:0]     start_d;
  logic                   out_of_range;

  assign index_ch.ready = (state_q == FS_IDLE);
  assign accept         = index_ch.valid && index_ch.ready;

  always_comb begin
    if (tile_len_q == '0) begin
      len_eff = TILE_LEN_W'(1);
    end else if (32'(tile_len_q) > MAX_TILE) begin
      len_eff = TILE_LEN_W'(MAX_TILE);
    end else begin
      len_eff = tile_len_q;
    end
  end

  assign ic_eff     = (index_cnt_q == '0) ? COUNT_W'(1) : index_cnt_q;
  assign oc_eff     = (outer_cnt_q == '0) ? COUNT_W'(1) : outer_cnt_q;
  assign last_index = ((17'(index_pos_q) + 17'd1) >= 17'(ic_eff));
  assign last_outer = ((17'(outer_pos_q) + 17'd1) >= 17'(oc_eff));
  assign jend       = last_index && last_outer;

  // negative index counts from the end of the axis
  assign idx_ext = 18'(index_ch.index_value);
  assign idx_w   = index_ch.index_value[INDEX_W-1] ? (idx_ext + signed'({2'b00, axis_q}))
                                                   : idx_ext;

  assign sum     = signed'({2'b00, prod_q}) + 34'(idx_w_q);
  assign start_d = 42'(sum) * 42'(signed'({1'b0, len_q}));

  assign out_of_range = start_q[41] || (unsigned'(start_q[40:0]) >= 41'(src_len_q));

  always_comb begin
    index_pos_d = index_pos_q;
    outer_pos_d = outer_pos_q;
    dest_base_d = dest_base_q;
    if (accept) begin
      if (jend) begin
        index_pos_d = '0;
        outer_pos_d = '0;
        dest_base_d = '0;
      end else begin
        dest_base_d = dest_base_q + ADDR_WIDTH'(len_eff);
        if (last_index) begin
          index_pos_d = '0;
          outer_pos_d = outer_pos_q + COUNT_W'(1);
        end else begin
          index_pos_d = index_pos_q + COUNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE:  if (accept) state_d = FS_SCALE;
      FS_SCALE: state_d = FS_PUSH;
      FS_PUSH:  if (push_ready_i) state_d = FS_IDLE;
      default:  state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_IDLE;
      axis_q      <= AXIS_W'(1);
      tile_len_q  <= TILE_LEN_W'(1);
      index_cnt_q <= COUNT_W'(1);
      outer_cnt_q <= COUNT_W'(1);
      src_len_q   <= '0;
      index_pos_q <= '0;
      outer_pos_q <= '0;
      dest_base_q <= '0;
    end else begin
      state_q     <= state_d;
      index_pos_q <= index_pos_d;
      outer_pos_q <= outer_pos_d;
      dest_base_q <= dest_base_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_AXIS_SIZE:     axis_q      <= cfg_data_i[AXIS_W-1:0];
          CFG_TILE_LENGTH:   tile_len_q  <= cfg_data_i[TILE_LEN_W-1:0];
          CFG_INDEX_COUNT:   index_cnt_q <= cfg_data_i[COUNT_W-1:0];
          CFG_OUTER_COUNT:   outer_cnt_q <= cfg_data_i[COUNT_W-1:0];
          CFG_SOURCE_LENGTH: src_len_q   <= cfg_data_i[SRC_LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q  <= 32'(outer_pos_q) * 32'(axis_q);
      idx_w_q <= idx_w;
      len_q   <= len_eff;
      dest_q  <= dest_base_q;
      jend_q  <= jend;
    end
    if (state_q == FS_SCALE) begin
      start_q <= start_d;
    end
  end

  assign push_valid_o        = (state_q == FS_PUSH);
  assign push_start_o        = out_of_range ? '0 : start_q[ADDR_WIDTH-1:0];
  assign push_dest_o         = dest_q;
  assign push_ctrl_o.len     = len_q;
  assign push_ctrl_o.copy    = !out_of_range;
  assign push_ctrl_o.job_end = jend_q;

endmodule

// ===== hw/rtl/agau_fifo.sv =====
`timescale 1ns / 1ps
module agau_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_data_o,
  output logic             empty_o
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o      = (count_q == CntW'(DEPTH));
  assign empty_o     = (count_q == '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && !empty_o;
  assign head_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/agau_back.sv =====
`timescale 1ns / 1ps
module agau_back #(
  parameter int ADDR_WIDTH = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  logic [ADDR_WIDTH-1:0] head_start_i,
  input  logic [ADDR_WIDTH-1:0] head_dest_i,
  input  agau_pkg::tile_ctrl_t  head_ctrl_i,
  output logic                  pop_o,
  agau_result_if.source         result_ch
);
  import agau_pkg::*;

  logic [TILE_LEN_W-1:0] elem_q;
  logic [TILE_LEN_W-1:0] elem_cnt;
  logic                  last_elem, emit;
  logic [ADDR_WIDTH-1:0] src_addr, dst_addr;

  logic                  out_valid_q;
  logic [OUT_ADDR_W-1:0] out_src_q, out_dst_q;
  logic                  out_copy_q, out_tend_q, out_jend_q;

  // a skipped tile yields a single result
  assign elem_cnt  = head_ctrl_i.copy ? head_ctrl_i.len : TILE_LEN_W'(1);
  assign last_elem = ((elem_q + TILE_LEN_W'(1)) == elem_cnt);
  assign emit      = head_valid_i && (!out_valid_q || result_ch.ready);
  assign pop_o     = emit && last_elem;

  assign src_addr = head_start_i + ADDR_WIDTH'(elem_q);
  assign dst_addr = head_dest_i + ADDR_WIDTH'(elem_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        elem_q <= last_elem ? '0 : elem_q + TILE_LEN_W'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_src_q  <= OUT_ADDR_W'(src_addr);
      out_dst_q  <= OUT_ADDR_W'(dst_addr);
      out_copy_q <= head_ctrl_i.copy;
      out_tend_q <= last_elem;
      out_jend_q <= last_elem && head_ctrl_i.job_end;
    end
  end

  assign result_ch.valid          = out_valid_q;
  assign result_ch.source_address = out_src_q;
  assign result_ch.dest_address   = out_dst_q;
  assign result_ch.copy_valid     = out_copy_q;
  assign result_ch.tile_end       = out_tend_q;
  assign result_ch.job_end        = out_jend_q;

endmodule

// ===== hw/rtl/agau_checker.sv =====
`timescale 1ns / 1ps
module agau_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             res_valid_i,
  input logic                             res_ready_i,
  input logic [agau_pkg::OUT_ADDR_W-1:0]  res_src_i,
  input logic [agau_pkg::OUT_ADDR_W-1:0]  res_dst_i,
  input logic                             res_copy_i,
  input logic                             res_tend_i,
  input logic                             res_jend_i
);
  import agau_pkg::*;

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_src_i) &&
    $stable(res_dst_i) && $stable(res_copy_i) && $stable(res_tend_i) && $stable(res_jend_i))
    else $error("result changed while stalled");

  // skipped tile is a single, closing result
  a_skip_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_copy_i |-> res_tend_i)
    else $error("skipped tile without tile_end");

  a_skip_src_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_copy_i |-> res_src_i == '0)
    else $error("skipped tile with non-zero source address");

  // job end only closes a tile
  a_job_end_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_jend_i |-> res_tend_i)
    else $error("job_end outside tile end");

endmodule

bind axis_gather_address_generator_unit agau_checker u_agau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (result_ch.valid),
  .res_ready_i (result_ch.ready),
  .res_src_i   (result_ch.source_address),
  .res_dst_i   (result_ch.dest_address),
  .res_copy_i  (result_ch.copy_valid),
  .res_tend_i  (result_ch.tile_end),
  .res_jend_i  (result_ch.job_end)
);

// ===== tb/gather_addr_tracker.sv =====
`timescale 1ns / 1ps
module gather_addr_tracker
  import agau_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  agau_index_if                 index_ch,
  agau_result_if                result_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    mismatch_count_o,
  output int                    beats_pending_o
);

  localparam int MAX_TILE_LEN = 64;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] src;
    logic [OUT_ADDR_W-1:0] dst;
    logic                  copy;
    logic                  tile_end;
    logic                  job_end;
  } addr_beat_t;

  addr_beat_t pending_beats[$];

  logic [AXIS_W-1:0]     axis_q;
  logic [TILE_LEN_W-1:0] tile_q;
  logic [COUNT_W-1:0]    icount_q;
  logic [COUNT_W-1:0]    ocount_q;
  logic [SRC_LEN_W-1:0]  srclen_q;
  logic [COUNT_W-1:0]    ipos_q;
  logic [COUNT_W-1:0]    opos_q;
  logic [OUT_ADDR_W-1:0] dbase_q;
  int                    mismatches;

  // expands one index into the element beats of its tile, then steps the loop
  function automatic void expand_index(input logic [INDEX_W-1:0] raw);
    longint     idx, start, len, ax, sl, ic, oc;
    bit         last_i, last_o, jend;
    addr_beat_t b;
    idx = longint'($signed(raw));
    ax  = longint'(axis_q);
    sl  = longint'(srclen_q);
    len = (tile_q == 0) ? 1 : ((tile_q > MAX_TILE_LEN) ? MAX_TILE_LEN : longint'(tile_q));
    ic  = (icount_q == 0) ? 1 : longint'(icount_q);
    oc  = (ocount_q == 0) ? 1 : longint'(ocount_q);
    if (idx < 0) idx = idx + ax;
    start  = (longint'(opos_q) * ax + idx) * len;
    last_i = (longint'(ipos_q) + 1) >= ic;
    last_o = (longint'(opos_q) + 1) >= oc;
    jend   = last_i && last_o;
    if (start < 0 || start >= sl) begin
      b = '{src: '0, dst: dbase_q, copy: 1'b0, tile_end: 1'b1, job_end: jend};
      pending_beats.push_back(b);
    end else begin
      for (longint e = 0; e < len; e++) begin
        b.src      = OUT_ADDR_W'(start + e);
        b.dst      = dbase_q + OUT_ADDR_W'(e);
        b.copy     = 1'b1;
        b.tile_end = (e + 1 == len);
        b.job_end  = (e + 1 == len) && jend;
        pending_beats.push_back(b);
      end
    end
    if (jend) begin
      ipos_q  = '0;
      opos_q  = '0;
      dbase_q = '0;
    end else begin
      dbase_q = dbase_q + OUT_ADDR_W'(len);
      if (last_i) begin
        ipos_q = '0;
        opos_q = opos_q + COUNT_W'(1);
      end else begin
        ipos_q = ipos_q + COUNT_W'(1);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    addr_beat_t got, want;
    if (!rst_ni) begin
      axis_q   = AXIS_W'(1);
      tile_q   = TILE_LEN_W'(1);
      icount_q = COUNT_W'(1);
      ocount_q = COUNT_W'(1);
      srclen_q = '0;
      ipos_q   = '0;
      opos_q   = '0;
      dbase_q  = '0;
      pending_beats.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_AXIS_SIZE:     axis_q   = cfg_data_i[AXIS_W-1:0];
          CFG_TILE_LENGTH:   tile_q   = cfg_data_i[TILE_LEN_W-1:0];
          CFG_INDEX_COUNT:   icount_q = cfg_data_i[COUNT_W-1:0];
          CFG_OUTER_COUNT:   ocount_q = cfg_data_i[COUNT_W-1:0];
          CFG_SOURCE_LENGTH: srclen_q = cfg_data_i[SRC_LEN_W-1:0];
          default: ;
        endcase
      end
      if (index_ch.valid && index_ch.ready) expand_index(index_ch.index_value);
      if (result_ch.valid && result_ch.ready) begin
        got = '{src: result_ch.source_address, dst: result_ch.dest_address,
                copy: result_ch.copy_valid, tile_end: result_ch.tile_end,
                job_end: result_ch.job_end};
        if (pending_beats.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: result with nothing outstanding: src %h dst %h copy %b tend %b jend %b",
                     $realtime, got.src, got.dst, got.copy, got.tile_end, got.job_end);
          mismatches++;
        end else begin
          want = pending_beats.pop_front();
          if (got.src !== want.src || got.dst !== want.dst || got.copy !== want.copy ||
              got.tile_end !== want.tile_end || got.job_end !== want.job_end) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("%0t: result mismatch", $realtime);
              $display("  exp src %h dst %h copy %b tend %b jend %b",
                       want.src, want.dst, want.copy, want.tile_end, want.job_end);
              $display("  got src %h dst %h copy %b tend %b jend %b",
                       got.src, got.dst, got.copy, got.tile_end, got.job_end);
            end
            mismatches++;
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    beats_pending_o  <= pending_beats.size();
  end

endmodule

// ===== tb/axis_gather_address_generator_unit_tb.sv =====
`timescale 1ns / 1ps
// Top: clock, reset, stimulus and verdict. Prediction and comparison live in
// gather_addr_tracker, which sits beside the block and watches both channels
// and the register port.
module axis_gather_address_generator_unit_tb;
  import agau_pkg::*;

  localparam int RANDOM_ITEMS = 190;
  localparam int QUIET_CYCLES = 16;      // front end is 3 deep plus a 2-entry tile queue
  localparam int CYCLE_LIMIT  = 300000;  // far above the slowest legal run
  localparam int MAX_TILE_LEN = 64;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int mismatch_count;
  int beats_pending;
  int cycles = 0;
  bit steady = 1'b0;  // when set, neither side inserts idle cycles

  agau_index_if  index_ch ();
  agau_result_if result_ch ();

  axis_gather_address_generator_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .index_ch   (index_ch),
    .result_ch  (result_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  gather_addr_tracker addr_tracker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .index_ch         (index_ch),
    .result_ch        (result_ch),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .beats_pending_o  (beats_pending)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake or lost result ends here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // idle with a chance of roughly 8 in 100 per roll, except during a steady stretch
  function automatic bit idle_roll();
    return !steady && ($urandom_range(0, 99) < 8);
  endfunction

  // Result side back-pressure, re-rolled every cycle once out of reset.
  always @(posedge clk_i) begin
    if (rst_ni) result_ch.ready <= !idle_roll();
  end

  // Presents one index and returns in the time step of the accepting edge, so
  // the caller can put up the next one (or drop valid) with a single assignment.
  task automatic send_index(input logic [INDEX_W-1:0] v);
    while (idle_roll()) begin
      index_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    index_ch.valid       <= 1'b1;
    index_ch.index_value <= v;
    do @(posedge clk_i); while (!index_ch.ready);
  endtask

  // Holds off the sender until every predicted result has come back, then lets
  // the pipeline settle so register writes land on an idle block.
  task automatic wait_idle();
    index_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (beats_pending != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // Back-to-back writes of all five registers; write enable stays high across
  // them and drops once afterwards.
  task automatic apply_config(input int axis, input int tile, input int icount,
                              input int ocount, input int srclen);
    cfg_reg_e regs[5];
    int       vals[5];
    regs = '{CFG_AXIS_SIZE, CFG_TILE_LENGTH, CFG_INDEX_COUNT, CFG_OUTER_COUNT,
             CFG_SOURCE_LENGTH};
    vals = '{axis, tile, icount, ocount, srclen};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= CFG_DATA_W'(vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly a legal index in [-axis, axis-1]; some raw 17-bit noise.
  function automatic logic [INDEX_W-1:0] pick_index(input int axis);
    int v;
    if (axis == 0 || $urandom_range(0, 99) < 15) return INDEX_W'($urandom);
    v = int'($urandom_range(0, 2 * axis - 1)) - axis;
    return INDEX_W'(v);
  endfunction

  initial begin
    int     sent;
    int     phase;
    int     r, axis, tile, len, icount, ocount, srclen, n;
    longint span;

    index_ch.valid       = 1'b0;
    index_ch.index_value = '0;
    result_ch.ready      = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_AXIS_SIZE;
    cfg_data_i           = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // Reset settings: source length zero, so the only tile is skipped and ends the job.
    send_index(INDEX_W'(0));
    wait_idle();

    // One full 3x2 job over a 10-slice axis, 4-element tiles, source exactly
    // covering it: plain tiles, a negative wrap, a wrap that still lands below
    // zero, a start just past the source end, and the job end.
    apply_config(10, 4, 3, 2, 80);
    send_index(INDEX_W'(0));
    send_index(INDEX_W'(9));
    send_index(INDEX_W'(-11));
    send_index(INDEX_W'(-1));
    send_index(INDEX_W'(10));
    send_index(INDEX_W'(-10));
    wait_idle();

    // Zero axis, zero tile length and zero counts: wrap adds nothing, tile
    // clamps to one element, each index is a whole job.
    apply_config(0, 0, 0, 0, 24'hFF_FFFF);
    send_index(INDEX_W'(65535));
    send_index(INDEX_W'(-65536));
    send_index(INDEX_W'(5));
    wait_idle();

    // Widest settings; oversize tile length clamps to the maximum tile.
    apply_config(65535, 127, 65535, 65535, 24'hFF_FFFF);
    send_index(INDEX_W'(65535));
    send_index(INDEX_W'(-65536));
    send_index(INDEX_W'(-1));
    wait_idle();

    // Index count cut below the current position: this index closes the job.
    apply_config(65535, MAX_TILE_LEN, 2, 1, 24'hFF_FFFF);
    send_index(INDEX_W'(7));
    send_index(INDEX_W'(0));
    wait_idle();

    // --- random phases ---
    // Each phase picks a setting, then mostly sends a whole job's worth of
    // indices against a source sized to fit; the rest are partial jobs or
    // arbitrary source lengths. The block drains between phases.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = (phase >= 4 && phase < 9);

      r    = $urandom_range(0, 99);
      axis = (r < 70) ? int'($urandom_range(1, 20)) :
             (r < 80) ? 0 :
             (r < 88) ? 65535 : int'($urandom_range(1, 65535));
      r    = $urandom_range(0, 99);
      tile = (r < 80) ? int'($urandom_range(1, 8)) :
             (r < 88) ? MAX_TILE_LEN : int'($urandom_range(0, 127));
      len  = (tile == 0) ? 1 : ((tile > MAX_TILE_LEN) ? MAX_TILE_LEN : tile);
      icount = ($urandom_range(0, 99) < 90) ? int'($urandom_range(1, 6)) : 0;
      ocount = ($urandom_range(0, 99) < 90) ? int'($urandom_range(1, 4)) : 0;

      span = longint'(axis) * ((ocount == 0) ? 1 : ocount) * len;
      r    = $urandom_range(0, 99);
      if (r < 75)
        srclen = (span > 24'hFF_FFFF) ? 24'hFF_FFFF : int'(span);
      else if (r < 85)
        srclen = (span > 0 && span <= 24'hFF_FFFF) ? int'(span) - 1 : 0;
      else
        srclen = int'($urandom_range(0, 24'hFF_FFFF));

      n = ($urandom_range(0, 99) < 80) ?
          ((icount == 0) ? 1 : icount) * ((ocount == 0) ? 1 : ocount) :
          int'($urandom_range(1, 5));

      apply_config(axis, tile, icount, ocount, srclen);
      repeat (n) send_index(pick_index(axis));
      sent += n;
      wait_idle();
      phase++;
    end
    steady = 1'b0;

    wait_idle();
    if (mismatch_count == 0 && beats_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
